// ----- rtl/core/hslamp_pkg.sv -----
// Shared widths, fixed-point constants and sextant codes for the HSL-to-RGB pipeline.
package hslamp_pkg;

  // Q1.15 input fields and the value that stands for 1.0
  localparam int Q_W = 16;
  localparam logic [Q_W-1:0] ONE_Q15 = 16'h8000;

  // Chroma at scale 2^30, channel levels at 2^45, amplitude product at 2^60
  localparam int CHROMA_W = 31;
  localparam int VAL_W    = 46;
  localparam int PROD_W   = 61;
  localparam int SCL_W    = PROD_W + 7;
  localparam int BYTE_W   = 8;

  // Hue sextant, named by the dominant channels
  typedef enum logic [2:0] {
    SEXT_RY = 3'd0,
    SEXT_YG = 3'd1,
    SEXT_GC = 3'd2,
    SEXT_CB = 3'd3,
    SEXT_BM = 3'd4,
    SEXT_MR = 3'd5
  } sextant_t;

  // Saturate a Q1.15 field to 1.0
  function automatic logic [Q_W-1:0] clamp_q15(input logic [Q_W-1:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

// ----- rtl/core/hslamp_chan.sv -----
// One output channel: scale a level by amplitude and by 255, keep the integer byte.
module hslamp_chan (
  input  logic                            clk,
  input  logic [hslamp_pkg::VAL_W-1:0]    val,
  input  logic [hslamp_pkg::Q_W-1:0]      amp,
  output logic [hslamp_pkg::BYTE_W-1:0]   level
);

  localparam int MUL_W = hslamp_pkg::VAL_W + hslamp_pkg::Q_W;

  logic [MUL_W-1:0]                 mul;
  logic [hslamp_pkg::PROD_W-1:0]    prod;
  logic [hslamp_pkg::SCL_W-1:0]     scaled;

  // Level times amplitude, at most 2^60
  assign mul = MUL_W'(val) * MUL_W'(amp);

  always_ff @(posedge clk) begin
    prod <= mul[hslamp_pkg::PROD_W-1:0];
  end

  // Times 255 as a shift and subtract; the byte is the part above 2^60
  assign scaled = (hslamp_pkg::SCL_W'(prod) << 8) - hslamp_pkg::SCL_W'(prod);

  always_ff @(posedge clk) begin
    level <= scaled[hslamp_pkg::SCL_W-1 -: hslamp_pkg::BYTE_W];
  end

endmodule

// ----- rtl/core/hsl_to_rgb_with_amplitude_top.sv -----
// Top level of the HSL-plus-amplitude to RGB pipeline.
//
//  channel  | direction | signals                                   | handshake
//  ---------+-----------+-------------------------------------------+------------------
//  command  | in        | hue, saturation, lightness, amplitude     | start, busy
//  result   | out       | red, green, blue                          | done (1 cycle)
//
// Six register stages; done is set in the same cycle as the result bytes of the
// last stage. A new beat is taken on every cycle; busy stays low.
// The stages hold the input fold, the chroma multiply, the hue-weight multiply, the
// lightness offset add, the per-channel amplitude multiply and the byte scaling.
// Reset clears the valid bits only; data registers carry no reset.
// The receiver cannot stall, so the pipeline never holds.
module hsl_to_rgb_with_amplitude_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [hslamp_pkg::Q_W-1:0]      hue,
  input  logic [hslamp_pkg::Q_W-1:0]      saturation,
  input  logic [hslamp_pkg::Q_W-1:0]      lightness,
  input  logic [hslamp_pkg::Q_W-1:0]      amplitude,
  output logic                            done,
  output logic [hslamp_pkg::BYTE_W-1:0]   red,
  output logic [hslamp_pkg::BYTE_W-1:0]   green,
  output logic [hslamp_pkg::BYTE_W-1:0]   blue
);

  localparam int LAT = 6;
  localparam int QX_W = hslamp_pkg::Q_W + 1;
  localparam int H6_W = hslamp_pkg::Q_W + 2;
  localparam int XM_W = hslamp_pkg::CHROMA_W + hslamp_pkg::Q_W;

  // Stage 1 logic
  logic [hslamp_pkg::Q_W-1:0] hue_c, sat_c, lig_c, amp_c;
  logic [QX_W-1:0]            twol, dev, omdev, hd, omhd;
  logic [H6_W-1:0]            h6, h6m1;
  logic [2:0]                 sext_raw;

  // Stage registers
  logic [hslamp_pkg::Q_W-1:0] s1_omdev, s1_sat, s1_lig, s1_amp, s1_omhd;
  hslamp_pkg::sextant_t       s1_sext;
  logic [hslamp_pkg::CHROMA_W-1:0] s2_chroma;
  logic [hslamp_pkg::Q_W-1:0] s2_lig, s2_amp, s2_omhd;
  hslamp_pkg::sextant_t       s2_sext;
  logic [hslamp_pkg::VAL_W-1:0] s3_cv, s3_xv, s3_mv;
  logic [hslamp_pkg::Q_W-1:0] s3_amp;
  hslamp_pkg::sextant_t       s3_sext;
  logic [hslamp_pkg::VAL_W-1:0] s4_r, s4_g, s4_b;
  logic [hslamp_pkg::Q_W-1:0] s4_amp;
  logic [5:1]                 vld;

  logic [31:0]                chroma_mul;
  logic [XM_W-1:0]            x_mul;
  logic [hslamp_pkg::VAL_W-1:0] sel_r, sel_g, sel_b;

  assign busy = 1'b0;

  // Clamp inputs, fold lightness and hue, find the sextant
  always_comb begin
    hue_c = hslamp_pkg::clamp_q15(hue);
    sat_c = hslamp_pkg::clamp_q15(saturation);
    lig_c = hslamp_pkg::clamp_q15(lightness);
    amp_c = hslamp_pkg::clamp_q15(amplitude);
    twol  = {lig_c, 1'b0};
    dev   = (twol >= QX_W'(hslamp_pkg::ONE_Q15)) ? twol - QX_W'(hslamp_pkg::ONE_Q15)
                                                 : QX_W'(hslamp_pkg::ONE_Q15) - twol;
    omdev = QX_W'(hslamp_pkg::ONE_Q15) - dev;
    h6    = (H6_W'(hue_c) << 2) + (H6_W'(hue_c) << 1);
    hd    = (h6[15] == 1'b1) ? QX_W'(h6[15:0]) - QX_W'(hslamp_pkg::ONE_Q15)
                             : QX_W'(hslamp_pkg::ONE_Q15) - QX_W'(h6[15:0]);
    omhd  = QX_W'(hslamp_pkg::ONE_Q15) - hd;
    h6m1  = h6 - H6_W'(1);
    sext_raw = (h6 == '0) ? 3'd0 : h6m1[H6_W-1 -: 3];
    if (sext_raw > 3'(hslamp_pkg::SEXT_MR)) begin
      sext_raw = 3'(hslamp_pkg::SEXT_MR);
    end
  end

  always_ff @(posedge clk) begin
    s1_omdev <= omdev[hslamp_pkg::Q_W-1:0];
    s1_sat   <= sat_c;
    s1_lig   <= lig_c;
    s1_amp   <= amp_c;
    s1_omhd  <= omhd[hslamp_pkg::Q_W-1:0];
    s1_sext  <= hslamp_pkg::sextant_t'(sext_raw);
  end

  // Chroma at scale 2^30
  assign chroma_mul = 32'(s1_omdev) * 32'(s1_sat);

  always_ff @(posedge clk) begin
    s2_chroma <= chroma_mul[hslamp_pkg::CHROMA_W-1:0];
    s2_lig    <= s1_lig;
    s2_amp    <= s1_amp;
    s2_omhd   <= s1_omhd;
    s2_sext   <= s1_sext;
  end

  // Secondary component, full chroma and lightness offset at scale 2^45
  assign x_mul = XM_W'(s2_chroma) * XM_W'(s2_omhd);

  always_ff @(posedge clk) begin
    s3_xv   <= x_mul[hslamp_pkg::VAL_W-1:0];
    s3_cv   <= hslamp_pkg::VAL_W'(s2_chroma) << 15;
    s3_mv   <= (hslamp_pkg::VAL_W'(s2_lig) << 30) - (hslamp_pkg::VAL_W'(s2_chroma) << 14);
    s3_amp  <= s2_amp;
    s3_sext <= s2_sext;
  end

  // Route components to channels by sextant
  always_comb begin
    unique case (s3_sext)
      hslamp_pkg::SEXT_RY: begin
        sel_r = s3_cv; sel_g = s3_xv; sel_b = '0;
      end
      hslamp_pkg::SEXT_YG: begin
        sel_r = s3_xv; sel_g = s3_cv; sel_b = '0;
      end
      hslamp_pkg::SEXT_GC: begin
        sel_r = '0;    sel_g = s3_cv; sel_b = s3_xv;
      end
      hslamp_pkg::SEXT_CB: begin
        sel_r = '0;    sel_g = s3_xv; sel_b = s3_cv;
      end
      hslamp_pkg::SEXT_BM: begin
        sel_r = s3_xv; sel_g = '0;    sel_b = s3_cv;
      end
      default: begin
        sel_r = s3_cv; sel_g = '0;    sel_b = s3_xv;
      end
    endcase
  end

  // Add the lightness offset
  always_ff @(posedge clk) begin
    s4_r   <= sel_r + s3_mv;
    s4_g   <= sel_g + s3_mv;
    s4_b   <= sel_b + s3_mv;
    s4_amp <= s3_amp;
  end

  // Amplitude and byte scaling, two stages per channel
  hslamp_chan u_red   (.clk(clk), .val(s4_r), .amp(s4_amp), .level(red));
  hslamp_chan u_green (.clk(clk), .val(s4_g), .amp(s4_amp), .level(green));
  hslamp_chan u_blue  (.clk(clk), .val(s4_b), .amp(s4_amp), .level(blue));

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[4:1], start && !busy};
      done <= vld[5];
    end
  end

  // Every accepted beat gives exactly one result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted beat produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  a_zero_amp: assert property (@(posedge clk) disable iff (rst)
    (start && amplitude == '0) |-> ##LAT (red == '0 && green == '0 && blue == '0))
    else $error("zero amplitude gave a nonzero channel");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    (start && saturation == '0) |-> ##LAT (red == green && green == blue))
    else $error("zero saturation gave unequal channels");

  a_white: assert property (@(posedge clk) disable iff (rst)
    (start && lightness == hslamp_pkg::ONE_Q15 && amplitude == hslamp_pkg::ONE_Q15)
      |-> ##LAT (red == '1 && green == '1 && blue == '1))
    else $error("full lightness and amplitude did not give white");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the HSL-plus-amplitude to RGB pipeline.
`timescale 1ns / 100ps

module tb;
  import hslamp_pkg::*;

  localparam int NUM_RANDOM  = 1450;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_PRINTED = 40;
  localparam logic [63:0] FULL = 64'd32768;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Directed beats: {hue, saturation, lightness, amplitude}
  localparam int NUM_DIRECTED = 23;
  localparam logic [63:0] DIRECTED [NUM_DIRECTED] = '{
    {16'd0,     16'd0,     16'd0,     16'd0},
    {16'd0,     16'd32768, 16'd16384, 16'd32768},
    {16'd2730,  16'd32768, 16'd16384, 16'd32768},
    {16'd8192,  16'd32768, 16'd16384, 16'd32768},
    {16'd13653, 16'd32768, 16'd16384, 16'd32768},
    {16'd19114, 16'd32768, 16'd16384, 16'd32768},
    {16'd24576, 16'd32768, 16'd16384, 16'd32768},
    {16'd30037, 16'd32768, 16'd16384, 16'd32768},
    {16'd16384, 16'd32768, 16'd16384, 16'd32768},
    {16'd32768, 16'd32768, 16'd16384, 16'd32768},
    {16'd5461,  16'd32768, 16'd16384, 16'd32768},
    {16'd5462,  16'd32768, 16'd16384, 16'd32768},
    {16'd10922, 16'd32768, 16'd16384, 16'd32768},
    {16'd10923, 16'd32768, 16'd16384, 16'd32768},
    {16'd21845, 16'd32768, 16'd16384, 16'd32768},
    {16'd21846, 16'd32768, 16'd16384, 16'd32768},
    {16'd27306, 16'd32768, 16'd16384, 16'd32768},
    {16'd27307, 16'd32768, 16'd16384, 16'd32768},
    {16'd65535, 16'd65535, 16'd65535, 16'd65535},
    {16'd32769, 16'd40000, 16'd50000, 16'd65535},
    {16'd12000, 16'd32768, 16'd32768, 16'd32768},
    {16'd12000, 16'd32768, 16'd16384, 16'd0},
    {16'd20000, 16'd32767, 16'd1,     16'd1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] hue = '0;
  logic [15:0] saturation = '0;
  logic [15:0] lightness = '0;
  logic [15:0] amplitude = '0;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  int          cycle_count = 0;

  hsl_to_rgb_with_amplitude_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .amplitude  (amplitude),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  // Saturate a Q1.15 field to 1.0, widened for the colour math
  function automatic logic [63:0] limit_q15(input logic [15:0] v);
    return (64'(v) > FULL) ? FULL : 64'(v);
  endfunction

  // floor(255 * p / 2^60), held to a byte
  function automatic logic [7:0] scale_to_byte(input logic [63:0] p);
    logic [71:0] t;
    t = ({8'd0, p} * 72'd255) >> 60;
    return (t > 72'd255) ? 8'hFF : t[7:0];
  endfunction

  // Exact fixed-point HSL-plus-amplitude to RGB, truncated at the end
  function automatic rgb_t predict_rgb(input logic [15:0] hue_in, input logic [15:0] sat_in,
                                       input logic [15:0] lig_in, input logic [15:0] amp_in);
    logic [63:0] h, s, l, a, twol, dev, chroma, h6, hm, hd, cv, xv, mv, r, g, b;
    int          idx;
    sextant_t    sext;
    rgb_t        res;
    h = limit_q15(hue_in);
    s = limit_q15(sat_in);
    l = limit_q15(lig_in);
    a = limit_q15(amp_in);
    // chroma at 2^30
    twol   = 2 * l;
    dev    = (twol >= FULL) ? twol - FULL : FULL - twol;
    chroma = (FULL - dev) * s;
    // hue position; a value on a boundary falls to the lower sextant
    h6  = h * 6;
    hm  = h6 % (2 * FULL);
    hd  = (hm >= FULL) ? hm - FULL : FULL - hm;
    idx = (h6 == 0) ? 0 : int'((h6 - 1) / FULL);
    if (idx > 5) begin
      idx = 5;
    end
    sext = sextant_t'(idx[2:0]);
    // channel levels at 2^45
    cv = chroma << 15;
    xv = chroma * (FULL - hd);
    mv = (l << 30) - (chroma << 14);
    case (sext)
      SEXT_RY: begin r = cv; g = xv; b = 0;  end
      SEXT_YG: begin r = xv; g = cv; b = 0;  end
      SEXT_GC: begin r = 0;  g = cv; b = xv; end
      SEXT_CB: begin r = 0;  g = xv; b = cv; end
      SEXT_BM: begin r = xv; g = 0;  b = cv; end
      default: begin r = cv; g = 0;  b = xv; end
    endcase
    res.red   = scale_to_byte((r + mv) * a);
    res.green = scale_to_byte((g + mv) * a);
    res.blue  = scale_to_byte((b + mv) * a);
    return res;
  endfunction

  // Expected colours in order of the beats taken, checked as results come out
  class rgb_scoreboard;
    rgb_t pending_rgb[$];
    int   beats_taken = 0;
    int   colours_checked = 0;
    int   mismatches = 0;

    task report(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display("[%0t] MISMATCH: %s", $time, what);
      end
    endtask

    function void note_beat(input logic [15:0] h, input logic [15:0] s,
                            input logic [15:0] l, input logic [15:0] a);
      pending_rgb.push_back(predict_rgb(h, s, l, a));
      beats_taken++;
    endfunction

    task check_result(input rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        report($sformatf("colour %02h %02h %02h with nothing pending",
                         got.red, got.green, got.blue));
        return;
      end
      want = pending_rgb.pop_front();
      colours_checked++;
      if (got.red !== want.red) begin
        report($sformatf("red %02h, want %02h", got.red, want.red));
      end
      if (got.green !== want.green) begin
        report($sformatf("green %02h, want %02h", got.green, want.green));
      end
      if (got.blue !== want.blue) begin
        report($sformatf("blue %02h, want %02h", got.blue, want.blue));
      end
    endtask
  endclass

  rgb_scoreboard sb = new();

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Watch both sides at each edge
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      sb.note_beat(hue, saturation, lightness, amplitude);
    end
    if (!rst && done) begin
      sb.check_result({red, green, blue});
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one beat, hold until it is taken, then idle for the gap
  task automatic send_beat(input logic [15:0] h, input logic [15:0] s,
                           input logic [15:0] l, input logic [15:0] a, input int gap);
    hue        <= h;
    saturation <= s;
    lightness  <= l;
    amplitude  <= a;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly short gaps, a few long ones; none at all inside a burst
  function automatic int pick_gap(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 45) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Mostly in range, some edges, some over one and some fully random bits
  function automatic logic [15:0] pick_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 16'($urandom_range(0, 32768));
    end
    if (roll < 72) begin
      case ($urandom_range(0, 4))
        0:       return 16'd0;
        1:       return 16'd1;
        2:       return 16'd16384;
        3:       return 16'd32767;
        default: return 16'd32768;
      endcase
    end
    if (roll < 85) begin
      return 16'($urandom_range(32769, 65535));
    end
    return 16'($urandom);
  endfunction

  // Hue lands near a sextant boundary a good share of the time
  function automatic logic [15:0] pick_hue();
    int k;
    int v;
    if ($urandom_range(0, 99) < 25) begin
      k = $urandom_range(0, 6);
      v = (k * 32768) / 6 + $urandom_range(0, 2) - 1;
      if (v < 0) begin
        v = 0;
      end
      return 16'(v);
    end
    return pick_level();
  endfunction

  initial begin
    logic [63:0] item;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, sextants and boundaries
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      item = DIRECTED[i];
      send_beat(item[63:48], item[47:32], item[31:16], item[15:0], pick_gap(i < 8));
    end

    // random colours, with back-to-back bursts now and then
    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_beat(pick_hue(), pick_level(), pick_level(), pick_level(),
                pick_gap((i % 150) < 40));
    end

    // drain the pipeline
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending_rgb.size() != 0) begin
      sb.report($sformatf("%0d colours never came out", sb.pending_rgb.size()));
    end

    $display("Sent %0d beats (%0d directed corners and sextant boundaries, rest random).",
             sb.beats_taken, NUM_DIRECTED);
    $display("Compared %0d colours, %0d mismatches.", sb.colours_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
